@@ design/b64d_pkg.sv @@
// shared types and character decode function for the base64 stream decoder
`default_nettype none
package b64d_pkg;

  localparam int unsigned GRP_BYTES = 3;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_PAD     = 8'h3d;

  localparam logic [5:0] SX_PLUS  = 6'd62;
  localparam logic [5:0] SX_SLASH = 6'd63;
  localparam logic [5:0] SX_LOWER = 6'd26;
  localparam logic [5:0] SX_DIGIT = 6'd52;

  typedef struct packed {
    logic       hit;
    logic       pad;
    logic [5:0] val;
  } sextet_t;

  // decoded bytes of one item, handed from decode to the emit buffer
  typedef struct packed {
    logic                           load;
    logic [GRP_BYTES-1:0][7:0]      bytes;
    logic [1:0]                     cnt;
    logic                           last;
  } grp_t;

  function automatic sextet_t classify(input logic [7:0] c);
    sextet_t r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d = c - CH_UPPER_A;
      r.hit = 1'b1;
      r.val = d[5:0];
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d = c - CH_LOWER_A;
      r.hit = 1'b1;
      r.val = d[5:0] + SX_LOWER;
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      d = c - CH_DIGIT_0;
      r.hit = 1'b1;
      r.val = d[5:0] + SX_DIGIT;
    end else if (c == CH_PLUS) begin
      r.hit = 1'b1;
      r.val = SX_PLUS;
    end else if (c == CH_SLASH) begin
      r.hit = 1'b1;
      r.val = SX_SLASH;
    end else if (c == CH_PAD) begin
      // a pad counts as 62 wherever its sextet is stored
      r.hit = 1'b1;
      r.pad = 1'b1;
      r.val = SX_PLUS;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/b64d_in_if.sv @@
// character channel interface
`default_nettype none
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       msg_last;

  modport source (output valid, output in_char, output msg_last, input ready);
  modport sink   (input valid, input in_char, input msg_last, output ready);
endinterface
`default_nettype wire

@@ design/b64d_out_if.sv @@
// decoded byte channel interface
`default_nettype none
interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       msg_end;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output msg_end, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                  input msg_end, output ready);
endinterface
`default_nettype wire

@@ design/base64_decode_stream_top.sv @@
// base64 stream decoder top level
// latency: results of an item are offered the cycle after it is accepted
// throughput: one character per cycle; an item that gives no result never waits,
//   while an item that gives bytes or ends a message waits while an earlier result remains
// reset: synchronous active-low rst_n clears group state and empties the buffer
`default_nettype none
module base64_decode_stream_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  b64d_in_if.sink     in_ch,
  b64d_out_if.source  out_ch
);

  b64d_pkg::grp_t grp;
  logic           space;
  logic           need;
  logic           accept;

  assign in_ch.ready = space || !need;
  assign accept      = in_ch.valid && (space || !need);

  b64d_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_char  (in_ch.in_char),
    .msg_last (in_ch.msg_last),
    .need     (need),
    .grp      (grp)
  );

  b64d_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .grp    (grp),
    .space  (space),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

@@ design/b64d_decode.sv @@
// group state and sextet to byte decode, updated on each accepted item
`default_nettype none
module b64d_decode (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    in_char,
  input  wire logic          msg_last,
  output logic               need,
  output b64d_pkg::grp_t     grp
);

  logic [1:0]  cnt_r, cnt_nxt;
  logic [17:0] store_r, store_nxt;
  logic        third_pad_r, third_pad_nxt;
  logic        stopped_r, stopped_nxt;

  b64d_pkg::sextet_t sx;
  logic              hit;
  logic [5:0]        s0, s1, s2;

  assign sx  = b64d_pkg::classify(in_char);
  assign hit = !stopped_r && sx.hit;
  assign s0  = store_r[17:12];
  assign s1  = store_r[11:6];
  assign s2  = store_r[5:0];

  always_comb begin
    cnt_nxt       = cnt_r;
    store_nxt     = store_r;
    third_pad_nxt = third_pad_r;
    stopped_nxt   = stopped_r;
    grp.bytes[0]  = {s0, s1[5:4]};
    grp.bytes[1]  = {s1[3:0], s2[5:2]};
    grp.bytes[2]  = {s2[1:0], sx.val};
    grp.cnt       = 2'd0;
    grp.last      = msg_last;
    if (hit) begin
      if (cnt_r != 2'd3) begin
        if (cnt_r == 2'd2 && sx.pad) begin
          third_pad_nxt = 1'b1;
        end
        store_nxt = {store_r[11:0], sx.val};
        cnt_nxt   = cnt_r + 2'd1;
      end else begin
        // fourth slot closes the group
        if (third_pad_r) begin
          grp.cnt     = 2'd1;
          stopped_nxt = 1'b1;
        end else if (sx.pad) begin
          grp.cnt     = 2'd2;
          stopped_nxt = 1'b1;
        end else begin
          grp.cnt = 2'd3;
        end
        cnt_nxt       = 2'd0;
        store_nxt     = '0;
        third_pad_nxt = 1'b0;
      end
    end
    if (msg_last) begin
      cnt_nxt       = 2'd0;
      store_nxt     = '0;
      third_pad_nxt = 1'b0;
      stopped_nxt   = 1'b0;
    end
    // only items that give a result use the emit buffer
    need     = (grp.cnt != 2'd0) || msg_last;
    grp.load = accept && need;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 2'd0;
      store_r     <= '0;
      third_pad_r <= 1'b0;
      stopped_r   <= 1'b0;
    end else if (accept) begin
      cnt_r       <= cnt_nxt;
      store_r     <= store_nxt;
      third_pad_r <= third_pad_nxt;
      stopped_r   <= stopped_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/b64d_emit.sv @@
// result buffer that hands out the decoded bytes of one group one per cycle while the receiver is ready
`default_nettype none
module b64d_emit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  b64d_pkg::grp_t      grp,
  output logic                space,
  b64d_out_if.source          out_ch
);

  logic [b64d_pkg::GRP_BYTES-1:0][7:0] bytes_r;
  logic [1:0]                          cnt_r;
  logic [1:0]                          idx_r;
  logic                                last_r;
  logic                                full_r;

  logic fin;
  logic pop;
  logic done;

  // a count of zero is the bare end-of-message marker
  assign fin  = (cnt_r == 2'd0) || (idx_r == cnt_r - 2'd1);
  assign pop  = full_r && out_ch.ready;
  assign done = pop && fin;
  assign space = !full_r || done;

  assign out_ch.valid      = full_r;
  assign out_ch.byte_valid = (cnt_r != 2'd0);
  assign out_ch.run_last   = fin;
  assign out_ch.msg_end    = last_r && fin;

  always_comb begin
    out_ch.out_byte = 8'd0;
    if (cnt_r != 2'd0) begin
      unique case (idx_r)
        2'd0:    out_ch.out_byte = bytes_r[0];
        2'd1:    out_ch.out_byte = bytes_r[1];
        2'd2:    out_ch.out_byte = bytes_r[2];
        default: out_ch.out_byte = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      idx_r  <= 2'd0;
      cnt_r  <= 2'd0;
      last_r <= 1'b0;
    end else if (grp.load) begin
      full_r  <= 1'b1;
      idx_r   <= 2'd0;
      cnt_r   <= grp.cnt;
      last_r  <= grp.last;
    end else if (done) begin
      full_r <= 1'b0;
    end else if (pop) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp.load) begin
      bytes_r <= grp.bytes;
    end
  end

endmodule
`default_nettype wire

@@ design/b64d_checker.sv @@
// port-level checks for the base64 stream decoder, bound to the top level
`default_nettype none
module b64d_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       byte_valid,
  input wire logic       run_last,
  input wire logic       msg_end
);

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && msg_end |-> run_last)
    else $error("msg_end without run_last");

  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> msg_end && out_byte == 8'd0)
    else $error("empty item that is not a clean message end");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(msg_end))
    else $error("stalled item changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("item offered right after reset");

endmodule

bind base64_decode_stream_top b64d_checker u_b64d_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .byte_valid (out_ch.byte_valid),
  .run_last   (out_ch.run_last),
  .msg_end    (out_ch.msg_end)
);
`default_nettype wire
